[hw/rtl/evwps_pkg.sv]
// ----------------------------------------------------------------------------
// evwps_pkg
// Shared widths, words and cell control types of the event window peak
// selector.
// ----------------------------------------------------------------------------
package evwps_pkg;

    localparam int unsigned EVENT_TIME_W       = 32;
    localparam int unsigned EVENT_SCORE_W      = 48;
    localparam int unsigned EVENT_INDEX_W      = 24;
    localparam int unsigned CLIP_W             = 10;
    localparam int unsigned TIME_FRAC_MAX      = 8;
    localparam int unsigned SPAN_W             = CLIP_W + TIME_FRAC_MAX;
    localparam int unsigned WINDOW_DEPTH_DEF   = 32;
    localparam int unsigned TIME_FRAC_BITS_DEF = 4;
    localparam logic [CLIP_W-1:0] CLIP_RESET   = CLIP_W'(50);

    typedef logic [EVENT_TIME_W-1:0]         event_time_t;
    typedef logic signed [EVENT_SCORE_W-1:0] event_score_t;
    typedef logic [EVENT_INDEX_W-1:0]        event_index_t;
    typedef logic [CLIP_W-1:0]               clip_t;
    typedef logic [SPAN_W-1:0]               span_t;

    typedef struct packed {
        event_time_t  event_time;
        event_score_t event_score;
        logic         batch_last;
    } event_word_t;

    typedef struct packed {
        event_index_t event_index;
        logic         keep;
        logic         forced;
        logic         batch_end;
        logic         run_last;
    } result_word_t;

    // one window entry as held by a cell
    typedef struct packed {
        logic         valid;
        logic         beaten;
        event_time_t  event_time;
        event_score_t event_score;
        event_index_t event_index;
    } entry_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic         shift;
        logic         compare;
        logic         load;
        event_time_t  cur_time;
        event_score_t cur_score;
        event_index_t new_index;
        logic         new_beaten;
        span_t        span;
    } cell_ctrl_t;

endpackage

[hw/rtl/evwps_stream_if.sv]
// ----------------------------------------------------------------------------
// evwps_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface evwps_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/evwps_cell.sv]
// ----------------------------------------------------------------------------
// evwps_cell
// One window slot: holds an entry, checks it against the current event and
// shifts toward the head of the chain when the oldest entry is popped.
// ----------------------------------------------------------------------------
module evwps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  evwps_pkg::cell_ctrl_t ctrl,
    input  evwps_pkg::entry_t   upstream,
    input  logic                prev_valid,
    output evwps_pkg::entry_t   entry,
    output logic                hit
);

    localparam int unsigned REACH_W = evwps_pkg::EVENT_TIME_W + 1;

    logic                   valid_reg, valid_next;
    logic                   beaten_reg, beaten_next;
    evwps_pkg::event_time_t  time_reg, time_next;
    evwps_pkg::event_score_t score_reg, score_next;
    evwps_pkg::event_index_t index_reg, index_next;

    logic [REACH_W-1:0] reach;
    logic               in_win;
    logic               take_new;

    // entry interacts when the new time is within clip past the stored time
    assign reach  = {1'b0, time_reg} + REACH_W'(ctrl.span);
    assign in_win = ({1'b0, ctrl.cur_time} <= reach);
    assign hit    = valid_reg && in_win && (score_reg >= ctrl.cur_score);

    // first empty slot takes the new event
    assign take_new = ctrl.load && !valid_reg && prev_valid;

    always_comb
    begin
        valid_next  = valid_reg;
        beaten_next = beaten_reg;
        time_next   = time_reg;
        score_next  = score_reg;
        index_next  = index_reg;
        if (ctrl.shift)
        begin
            valid_next  = upstream.valid;
            beaten_next = upstream.beaten;
            time_next   = upstream.event_time;
            score_next  = upstream.event_score;
            index_next  = upstream.event_index;
        end
        else if (ctrl.compare)
        begin
            if (valid_reg && in_win && (ctrl.cur_score > score_reg))
                beaten_next = 1'b1;
        end
        else if (take_new)
        begin
            valid_next  = 1'b1;
            beaten_next = ctrl.new_beaten;
            time_next   = ctrl.cur_time;
            score_next  = ctrl.cur_score;
            index_next  = ctrl.new_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            beaten_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            beaten_reg <= beaten_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        score_reg <= score_next;
        index_reg <= index_next;
    end

    assign entry = '{valid:       valid_reg,
                     beaten:      beaten_reg,
                     event_time:  time_reg,
                     event_score: score_reg,
                     event_index: index_reg};

endmodule

[hw/rtl/event_window_peak_selector_core.sv]
// ----------------------------------------------------------------------------
// event_window_peak_selector_core
// Non-maximum suppression over time-sorted events using a chain of window
// cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// an event passes through accept, pop check, compare, insert and finish, with a
// pop step for each result it causes and a flush check at a batch end
// one event is in work at a time; a pop waits while the output side is full
// results leave through a one-word hold stage and an output register, so the
// last result of an event can wait in the output register while the next event is accepted
// reset empties the window at once and loads the clip register with 50
module event_window_peak_selector_core #(
    parameter int unsigned WINDOW_DEPTH   = evwps_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned TIME_FRAC_BITS = evwps_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    evwps_stream_if.sink          events,
    evwps_stream_if.source        results,
    evwps_stream_if.sink          cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CMP,
        ST_FORCE,
        ST_INSERT,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    evwps_pkg::clip_t         clip_reg, clip_next;
    evwps_pkg::event_time_t   time_reg, time_next;
    evwps_pkg::event_score_t  score_reg, score_next;
    logic                     last_reg, last_next;
    logic                     beaten_reg, beaten_next;
    evwps_pkg::event_index_t  count_reg, count_next;
    evwps_pkg::result_word_t  pend_reg, pend_next;
    logic                     pend_valid_reg, pend_valid_next;
    evwps_pkg::result_word_t  out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    evwps_pkg::cell_ctrl_t    ctrl;
    evwps_pkg::entry_t        cell_entry [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]  valid_vec;
    logic [WINDOW_DEPTH-1:0]  hit_vec;
    logic                     head_in_win;
    logic                     out_free;
    logic                     slot_ok;
    logic                     do_pop;
    logic                     pop_forced;
    evwps_pkg::result_word_t  pop_word;
    evwps_pkg::span_t         span;

    assign span = evwps_pkg::span_t'(clip_reg) << TIME_FRAC_BITS;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++)
        begin : g_cell
            evwps_pkg::entry_t up;
            logic              prev_v;
            if (gi == WINDOW_DEPTH - 1)
            begin : g_tail
                assign up = '0;
            end
            else
            begin : g_mid
                assign up = cell_entry[gi+1];
            end
            if (gi == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = cell_entry[gi-1].valid;
            end
            evwps_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .upstream   (up),
                .prev_valid (prev_v),
                .entry      (cell_entry[gi]),
                .hit        (hit_vec[gi])
            );
            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    // head entry still reaches the current time
    assign head_in_win = ({1'b0, time_reg} <=
                          ({1'b0, cell_entry[0].event_time} +
                           (evwps_pkg::EVENT_TIME_W + 1)'(span)));

    assign out_free = !out_valid_reg || results.ready;
    assign slot_ok  = !pend_valid_reg || out_free;

    assign pop_word = '{event_index: cell_entry[0].event_index,
                        keep:        !cell_entry[0].event_score[evwps_pkg::EVENT_SCORE_W-1]
                                     && (|cell_entry[0].event_score)
                                     && !cell_entry[0].beaten,
                        forced:      pop_forced,
                        batch_end:   1'b0,
                        run_last:    1'b0};

    always_comb
    begin
        state_next      = state_reg;
        clip_next       = clip_reg;
        time_next       = time_reg;
        score_next      = score_reg;
        last_next       = last_reg;
        beaten_next     = beaten_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        do_pop          = 1'b0;
        pop_forced      = 1'b0;

        if (cfg.valid)
            clip_next = cfg.data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (events.valid)
                begin
                    time_next  = events.data.event_time;
                    score_next = events.data.event_score;
                    last_next  = events.data.batch_last;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (cell_entry[0].valid && !head_in_win)
                    do_pop = slot_ok;
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                beaten_next = |hit_vec;
                state_next  = valid_vec[WINDOW_DEPTH-1] ? ST_FORCE : ST_INSERT;
            end
            ST_FORCE:
            begin
                pop_forced = 1'b1;
                do_pop     = slot_ok;
                if (slot_ok)
                    state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                count_next = last_reg ? '0 : count_reg + 1'b1;
                state_next = last_reg ? ST_FLUSH : ST_FINISH;
            end
            ST_FLUSH:
            begin
                if (cell_entry[0].valid)
                    do_pop = slot_ok;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_next           = pend_reg;
                    out_next.run_last  = 1'b1;
                    out_next.batch_end = last_reg;
                    out_valid_next     = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new decision pushes the held word out first
        if (do_pop)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = pop_word;
            pend_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        ctrl.shift      = do_pop;
        ctrl.compare    = (state_reg == ST_CMP);
        ctrl.load       = (state_reg == ST_INSERT);
        ctrl.cur_time   = time_reg;
        ctrl.cur_score  = score_reg;
        ctrl.new_index  = count_reg;
        ctrl.new_beaten = beaten_reg;
        ctrl.span       = span;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clip_reg       <= evwps_pkg::CLIP_RESET;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clip_reg       <= clip_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        score_reg  <= score_next;
        beaten_reg <= beaten_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign events.ready  = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    a_accept_starts_pop: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && events.ready |=> state_reg == ST_POP)
        else $error("accepted word did not start the pop pass");

    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |-> !valid_vec[WINDOW_DEPTH-1])
        else $error("insert with full window");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && last_reg |-> !valid_vec[0])
        else $error("batch end left entries in window");

    a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + 1'b1))
        else $error("window slots not contiguous");

    a_batch_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.batch_end |-> results.data.run_last)
        else $error("batch end word not marked last of run");

endmodule

[test/tb_event_window_peak_selector_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_window_peak_selector_core
// Streams time-sorted events into the peak selector and checks every decision
// against a local window-store predictor, over several clip sizes and under
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_event_window_peak_selector_core;

    localparam int unsigned WIN_DEPTH      = 32;
    localparam int unsigned TIME_FRAC      = 4;
    localparam int unsigned REACH_W        = evwps_pkg::EVENT_TIME_W + 1;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned NUM_PHASES     = 5;

    localparam evwps_pkg::event_score_t SCORE_MAX =
        {1'b0, {(evwps_pkg::EVENT_SCORE_W-1){1'b1}}};
    localparam evwps_pkg::event_score_t SCORE_MIN =
        {1'b1, {(evwps_pkg::EVENT_SCORE_W-1){1'b0}}};

    typedef logic [REACH_W-1:0] reach_t;

    logic clk;
    logic rst_n;

    evwps_stream_if #(.payload_t(evwps_pkg::event_word_t))  ev_if  ();
    evwps_stream_if #(.payload_t(evwps_pkg::result_word_t)) res_if ();
    evwps_stream_if #(.payload_t(evwps_pkg::clip_t))        cfg_if ();

    event_window_peak_selector_core #(
        .WINDOW_DEPTH   (WIN_DEPTH),
        .TIME_FRAC_BITS (TIME_FRAC)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (ev_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    // window store of the predictor, slot 0 oldest
    evwps_pkg::event_time_t  held_time   [WIN_DEPTH];
    evwps_pkg::event_score_t held_score  [WIN_DEPTH];
    evwps_pkg::event_index_t held_index  [WIN_DEPTH];
    bit                      held_beaten [WIN_DEPTH];
    int                      held_count    = 0;
    evwps_pkg::event_index_t arrival_count = '0;
    evwps_pkg::clip_t        clip_now      = evwps_pkg::CLIP_RESET;

    evwps_pkg::event_word_t  queued_events[$];
    evwps_pkg::result_word_t expected_decisions[$];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold      = 1'b0;
    bit  hold_go      = 1'b0;
    bit  ev_fire      = 1'b0;
    int  quiet_cycles = 0;

    int  mismatches    = 0;
    int  events_taken  = 0;
    int  results_seen  = 0;
    int  forced_seen   = 0;
    int  kept_seen     = 0;
    int  batches_ended = 0;
    int  clip_writes   = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic bit in_window(input evwps_pkg::event_time_t stored,
                                     input evwps_pkg::event_time_t now);
        reach_t reach;
        reach = {1'b0, stored} + (reach_t'(clip_now) << TIME_FRAC);
        return {1'b0, now} <= reach;
    endfunction

    function automatic void decide_oldest(input bit forced);
        evwps_pkg::result_word_t r;
        r.event_index = held_index[0];
        r.keep        = (held_score[0] > 0) && !held_beaten[0];
        r.forced      = forced;
        r.batch_end   = 1'b0;
        r.run_last    = 1'b0;
        expected_decisions.push_back(r);
        for (int i = 0; i + 1 < WIN_DEPTH; i++)
        begin
            held_time[i]   = held_time[i+1];
            held_score[i]  = held_score[i+1];
            held_index[i]  = held_index[i+1];
            held_beaten[i] = held_beaten[i+1];
        end
        held_beaten[WIN_DEPTH-1] = 1'b0;
        held_count--;
    endfunction

    function automatic void predict_event(input evwps_pkg::event_word_t ev);
        evwps_pkg::event_time_t  t;
        evwps_pkg::event_score_t s;
        bit                      beaten;
        int                      prior_count;
        evwps_pkg::result_word_t tail;
        t           = ev.event_time;
        s           = ev.event_score;
        beaten      = 1'b0;
        prior_count = expected_decisions.size();

        // an out-of-window entry behind an in-window oldest one just waits
        while (held_count > 0 && !in_window(held_time[0], t))
            decide_oldest(1'b0);

        for (int i = 0; i < held_count; i++)
        begin
            if (in_window(held_time[i], t))
            begin
                if (held_score[i] >= s)
                    beaten = 1'b1;
                if (s > held_score[i])
                    held_beaten[i] = 1'b1;
            end
        end

        if (held_count >= WIN_DEPTH)
            decide_oldest(1'b1);

        held_time[held_count]   = t;
        held_score[held_count]  = s;
        held_index[held_count]  = arrival_count;
        held_beaten[held_count] = beaten;
        held_count++;
        arrival_count++;

        if (ev.batch_last)
        begin
            while (held_count > 0)
                decide_oldest(1'b0);
            tail = expected_decisions.pop_back();
            tail.batch_end = 1'b1;
            expected_decisions.push_back(tail);
            arrival_count = '0;
        end

        if (expected_decisions.size() > prior_count)
        begin
            tail = expected_decisions.pop_back();
            tail.run_last = 1'b1;
            expected_decisions.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver, receiver and monitor
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : event_driver
        if (rst_n && (!ev_if.valid || ev_fire))
        begin
            if (queued_events.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                ev_if.data  <= queued_events.pop_front();
                ev_if.valid <= 1'b1;
            end
            else
            begin
                ev_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : result_receiver
        res_if.ready <= rst_n && !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // long receiver hold-off, the block has to back up into its input
    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin : decision_monitor
        evwps_pkg::result_word_t got;
        evwps_pkg::result_word_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.data;
                if (expected_decisions.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    check_field("event_index", got.event_index, want.event_index);
                    check_field("keep", got.keep, want.keep);
                    check_field("forced", got.forced, want.forced);
                    check_field("batch_end", got.batch_end, want.batch_end);
                    check_field("run_last", got.run_last, want.run_last);
                end
                if (got.forced === 1'b1)
                    forced_seen++;
                if (got.keep === 1'b1)
                    kept_seen++;
                if (got.batch_end === 1'b1)
                    batches_ended++;
                results_seen++;
            end
            // results of earlier events are checked before this one is predicted
            if (ev_if.valid && ev_if.ready)
            begin
                predict_event(ev_if.data);
                events_taken++;
            end
        end
        ev_fire = rst_n && ev_if.valid && ev_if.ready;
    end

    always @(posedge clk)
    begin : watchdog
        if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no word moved for %0d cycles", $realtime, quiet_cycles);
            $display("tb_event_window_peak_selector_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_event(input evwps_pkg::event_time_t t,
                               input evwps_pkg::event_score_t s, input bit last);
        evwps_pkg::event_word_t ev;
        ev.event_time  = t;
        ev.event_score = s;
        ev.batch_last  = last;
        queued_events.push_back(ev);
    endtask

    task automatic write_clip(input evwps_pkg::clip_t value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        clip_now = value;
        clip_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // wait for every queued event to go in and every decision to come out
    task automatic wait_drained();
        while (queued_events.size() > 0 || ev_if.valid || expected_decisions.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int next_step(input int span);
        case ($urandom_range(0, 9))
            0, 1:    return 0;
            2, 3, 4: return $urandom_range(0, span / 4 + 1);
            5, 6:    return (span == 0) ? $urandom_range(0, 1) : span + $urandom_range(0, 2) - 1;
            7:       return $urandom_range(span + 1, 3 * span + 20);
            8:       return int'($urandom);
            default: return -int'($urandom_range(1, span + 16));
        endcase
    endfunction

    function automatic evwps_pkg::event_score_t random_score();
        case ($urandom_range(0, 7))
            0:       return evwps_pkg::event_score_t'(int'($urandom_range(0, 6)) - 3);
            1:       return SCORE_MAX;
            2:       return SCORE_MIN;
            3, 4:    return evwps_pkg::event_score_t'({$urandom, $urandom});
            default: return evwps_pkg::event_score_t'(int'($urandom_range(0, 1000)) - 200);
        endcase
    endfunction

    // batches of sorted events, with dense bursts that overflow the store,
    // and a share of backward steps; the last event always closes its batch
    task automatic queue_random_events(input int count, input int span);
        evwps_pkg::event_time_t t;
        int                     left;
        int                     batch_len;
        bit                     burst;
        left = count;
        while (left > 0)
        begin
            burst     = ($urandom_range(0, 3) == 0);
            batch_len = burst ? $urandom_range(WIN_DEPTH + 1, WIN_DEPTH + 12)
                              : $urandom_range(1, 20);
            if (batch_len > left)
                batch_len = left;
            t = $urandom;
            for (int i = 0; i < batch_len; i++)
            begin
                t = t + evwps_pkg::event_time_t'(burst ? $urandom_range(0, 3)
                                                       : next_step(span));
                queue_event(t, random_score(), i == batch_len - 1);
            end
            left -= batch_len;
        end
    endtask

    initial
    begin : main_sequence
        evwps_pkg::clip_t phase_clip [NUM_PHASES];
        int               phase_tx   [NUM_PHASES];
        int               phase_rx   [NUM_PHASES];
        int               phase_len  [NUM_PHASES];

        rst_n        = 1'b0;
        ev_if.valid  = 1'b0;
        ev_if.data   = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
            held_beaten[i] = 1'b0;

        phase_clip = '{evwps_pkg::clip_t'(1023), evwps_pkg::clip_t'(1),
                       evwps_pkg::clip_t'(0),
                       evwps_pkg::clip_t'($urandom_range(2, 1022)),
                       evwps_pkg::clip_t'(200)};
        phase_tx   = '{0, 63, 0, 23, 0};
        phase_rx   = '{0, 0, 63, 23, 0};
        phase_len  = '{90, 70, 60, 90, 50};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset clip size of 50 (span 800)
        queue_event(32'd0, SCORE_MAX, 1'b0);
        queue_event(32'd800, SCORE_MAX, 1'b0);     // equal score on window edge
        queue_event(32'd801, 48'sd7, 1'b0);        // first event falls out of window
        queue_event(32'd801, 48'sd0, 1'b0);        // zero score, equal time
        queue_event(32'd900, SCORE_MIN, 1'b0);
        queue_event(32'd905, 48'sd8, 1'b0);        // later strictly greater
        queue_event(32'd700, 48'sd100, 1'b0);      // time goes backward
        queue_event(32'd5000, -48'sd1, 1'b0);
        queue_event(32'd5000, -48'sd1, 1'b1);      // negative scores, batch end
        queue_event(32'd10, 48'sd1, 1'b1);         // single event batch
        queue_event(32'hFFFF_FC00, 48'sd3, 1'b0);  // window ends short of the time wrap
        queue_event(32'hFFFF_FFFF, 48'sd2, 1'b0);
        queue_event(32'hFFFF_FFFF, 48'sd3, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tx_idle_pct  = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            write_clip(phase_clip[p]);
            if (p == NUM_PHASES - 1)
                hold_go = 1'b1;
            queue_random_events(phase_len[p], int'(phase_clip[p]) << TIME_FRAC);
            wait_drained();
        end

        if (expected_decisions.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_decisions.size()));

        $display("run covered %0d events and %0d decisions over %0d clip writes",
                 events_taken, results_seen, clip_writes);
        $display("%0d kept, %0d forced by store overflow, %0d batches closed",
                 kept_seen, forced_seen, batches_ended);
        if (mismatches == 0)
            $display("tb_event_window_peak_selector_core: PASS");
        else
            $display("tb_event_window_peak_selector_core: FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/evwps_pkg.sv
hw/rtl/evwps_stream_if.sv
hw/rtl/evwps_cell.sv
hw/rtl/event_window_peak_selector_core.sv
test/tb_event_window_peak_selector_core.sv
